// File: rtl/psbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbb_pkg: shared types and constants for the per-site burst breaker
// Register indexes, halt reasons, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package psbb_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 4096;

  localparam logic [2:0] CFG_MODE_UNSAFE  = 3'd0;
  localparam logic [2:0] CFG_FEATURE_MASK = 3'd1;
  localparam logic [2:0] CFG_SUBSYS_MASK  = 3'd2;
  localparam logic [2:0] CFG_BURST_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_WINDOW_LEN   = 3'd4;

  localparam logic [31:0] BURST_LIMIT_RST = 32'd10000;
  localparam logic [31:0] WINDOW_LEN_RST  = 32'd1000;
  localparam logic [9:0]  SUMMARY_MASK    = 10'h3FF;

  typedef enum logic [2:0] {
    RSN_NONE   = 3'd0,
    RSN_POLICY = 3'd1,
    RSN_ZERO   = 3'd2,
    RSN_FULL   = 3'd3,
    RSN_BREAK  = 3'd4
  } reason_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PROBE,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear_step;  // write one empty row during the clearing pass
    logic load;        // capture a word, set first probe address
    logic read;        // issue memory read at probe address
    logic advance;     // step probe address
    logic early_halt;  // finish with policy or zero-key halt
    logic full_halt;   // finish with table-full halt
    logic update;      // write slot and finish with hit result
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic early;       // captured word halts before lookup
    logic hit;         // read slot matches or is empty
    logic last_probe;  // all slots probed
  } sts_t;

endpackage

// File: rtl/per_site_burst_breaker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_site_burst_breaker_unit: per-site halt/continue decision with burst
// breaker over a linear-probe site table.
//
//   channel  ports                        direction
//   in       in_valid / in_stall, fields  word in
//   out      out_valid / out_stall, fields word out
//   cfg      cfg_write, cfg_index, cfg_data write only
//
// A word halted before lookup goes from the read state straight to output;
// otherwise it walks probe steps of the single-port slot memory until a hit,
// then updates the slot, or halts as table-full after every slot is probed;
// one word at a time. After reset a clearing pass empties the table; no word
// is taken meanwhile. The result is held in out fields until taken.
// ----------------------------------------------------------------------------
module per_site_burst_breaker_unit #(
  parameter int unsigned TABLE_SLOTS = psbb_pkg::TABLE_SLOTS_DEF,
  localparam int unsigned CW = $clog2(TABLE_SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_write,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_feature_id,
  input  logic [2:0]    in_subsystem_id,
  input  logic          in_site_valid,
  input  logic [63:0]   in_site_key,
  input  logic [63:0]   in_now_ms,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_halt,
  output logic [2:0]    out_halt_reason,
  output logic          out_first_hit,
  output logic [31:0]   out_window_hit_count,
  output logic [63:0]   out_total_hit_count,
  output logic          out_summary_due,
  output logic [CW-1:0] out_distinct_sites,
  output logic [63:0]   out_breaker_trip_count,
  output logic [63:0]   out_overflow_count,
  output logic [63:0]   out_halt_count,
  output logic [63:0]   out_continue_count
);

  psbb_pkg::cmd_t cmd;
  psbb_pkg::sts_t sts;

  psbb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_stall, .out_valid,
    .sts, .cmd
  );

  psbb_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
    .clk, .rst_n, .cfg_write, .cfg_index, .cfg_data,
    .in_feature_id, .in_subsystem_id, .in_site_valid, .in_site_key, .in_now_ms,
    .cmd, .sts,
    .out_halt, .out_halt_reason, .out_first_hit, .out_window_hit_count,
    .out_total_hit_count, .out_summary_due, .out_distinct_sites,
    .out_breaker_trip_count, .out_overflow_count, .out_halt_count,
    .out_continue_count
  );

endmodule

// File: rtl/psbb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbb_ctrl: controller for the per-site burst breaker
// Sequences the clearing pass, the probe walk and the result handoff.
// ----------------------------------------------------------------------------
module psbb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_stall,
  output logic             out_valid,
  input  psbb_pkg::sts_t   sts,
  output psbb_pkg::cmd_t   cmd
);

  psbb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psbb_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psbb_pkg::ST_CLEAR: if (sts.clear_done) state_nxt = psbb_pkg::ST_IDLE;
      psbb_pkg::ST_IDLE: if (in_valid) state_nxt = psbb_pkg::ST_READ;
      psbb_pkg::ST_READ: begin
        if (sts.early) state_nxt = psbb_pkg::ST_OUT;
        else state_nxt = psbb_pkg::ST_PROBE;
      end
      psbb_pkg::ST_PROBE: begin
        if (sts.hit) state_nxt = psbb_pkg::ST_UPDATE;
        else if (sts.last_probe) state_nxt = psbb_pkg::ST_OUT;
      end
      psbb_pkg::ST_UPDATE: state_nxt = psbb_pkg::ST_OUT;
      psbb_pkg::ST_OUT: if (!out_stall) state_nxt = psbb_pkg::ST_IDLE;
      default: state_nxt = psbb_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      psbb_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
      psbb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      psbb_pkg::ST_READ: begin
        cmd.early_halt = sts.early;
        cmd.read       = !sts.early;
      end
      psbb_pkg::ST_PROBE: begin
        if (sts.hit) begin
          cmd.update = 1'b1;
        end else if (sts.last_probe) begin
          cmd.full_halt = 1'b1;
        end else begin
          cmd.advance = 1'b1;
          cmd.read    = 1'b1;
        end
      end
      psbb_pkg::ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == psbb_pkg::ST_IDLE)
    else $error("input taken outside idle");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");
  a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.early_halt, cmd.full_halt, cmd.update}) <= 1)
    else $error("two finish commands");

endmodule

// File: rtl/psbb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbb_dp: datapath for the per-site burst breaker
// Config registers, slot memory, probe address, window logic, totals and the
// result register.
// ----------------------------------------------------------------------------
module psbb_dp #(
  parameter int unsigned TABLE_SLOTS = psbb_pkg::TABLE_SLOTS_DEF,
  localparam int unsigned AW = $clog2(TABLE_SLOTS),
  localparam int unsigned CW = $clog2(TABLE_SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [1:0]        in_feature_id,
  input  logic [2:0]        in_subsystem_id,
  input  logic              in_site_valid,
  input  logic [63:0]       in_site_key,
  input  logic [63:0]       in_now_ms,
  input  psbb_pkg::cmd_t    cmd,
  output psbb_pkg::sts_t    sts,
  output logic              out_halt,
  output logic [2:0]        out_halt_reason,
  output logic              out_first_hit,
  output logic [31:0]       out_window_hit_count,
  output logic [63:0]       out_total_hit_count,
  output logic              out_summary_due,
  output logic [CW-1:0]     out_distinct_sites,
  output logic [63:0]       out_breaker_trip_count,
  output logic [63:0]       out_overflow_count,
  output logic [63:0]       out_halt_count,
  output logic [63:0]       out_continue_count
);

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] total;
    logic [63:0] wstart;
    logic [31:0] whits;
    logic        seen;
  } slot_t;

  logic        mode_r;
  logic [3:0]  fmask_r;
  logic [7:0]  smask_r;
  logic [31:0] limit_r, wlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      fmask_r <= '0;
      smask_r <= '0;
      limit_r <= psbb_pkg::BURST_LIMIT_RST;
      wlen_r  <= psbb_pkg::WINDOW_LEN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        psbb_pkg::CFG_MODE_UNSAFE:  mode_r  <= cfg_data[0];
        psbb_pkg::CFG_FEATURE_MASK: fmask_r <= cfg_data[3:0];
        psbb_pkg::CFG_SUBSYS_MASK:  smask_r <= cfg_data[7:0];
        psbb_pkg::CFG_BURST_LIMIT:  limit_r <= cfg_data;
        psbb_pkg::CFG_WINDOW_LEN:   wlen_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [1:0]  feat_r;
  logic [2:0]  sub_r;
  logic        sval_r;
  logic [63:0] key_r, now_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      feat_r <= in_feature_id;
      sub_r  <= in_subsystem_id;
      sval_r <= in_site_valid;
      key_r  <= in_site_key;
      now_r  <= in_now_ms;
    end
  end

  logic allowed;
  assign allowed = mode_r && fmask_r[feat_r] && smask_r[sub_r] && sval_r;
  assign sts.early = !allowed || (key_r == '0);

  // probe address, count and clear sweep
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] probes_r, probes_nxt;
  logic [AW-1:0] clr_r;
  logic          clr_done_r;

  always_comb begin
    addr_nxt   = addr_r;
    probes_nxt = probes_r;
    if (cmd.load) begin
      addr_nxt   = in_site_key[AW-1:0];
      probes_nxt = '0;
    end else if (cmd.advance) begin
      addr_nxt   = (addr_r == AW'(TABLE_SLOTS - 1)) ? '0 : addr_r + 1'b1;
      probes_nxt = probes_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    probes_r <= probes_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clr_done_r <= 1'b0;
    end else if (cmd.clear_step) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == AW'(TABLE_SLOTS - 1)) clr_done_r <= 1'b1;
    end
  end
  assign sts.clear_done = clr_done_r;

  // slot memory
  slot_t mem [TABLE_SLOTS];
  slot_t rd_r, wr_d;
  logic  we;
  logic [AW-1:0] wa;

  assign we = cmd.clear_step || cmd.update;
  assign wa = cmd.clear_step ? clr_r : addr_r;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= cmd.clear_step ? '0 : wr_d;
    if (cmd.read) rd_r <= mem[addr_nxt];
  end

  logic empty;
  assign empty = rd_r.key == '0;
  assign sts.hit = empty || (rd_r.key == key_r);
  assign sts.last_probe = probes_r == CW'(TABLE_SLOTS - 1);

  // hit update
  slot_t cur;
  logic  restart;
  logic [63:0] elapsed;
  logic [31:0] whits;
  logic [63:0] thits;
  logic        trip;

  always_comb begin
    cur = empty ? slot_t'{key: key_r, total: '0, wstart: '0, whits: '0, seen: 1'b0}
                : rd_r;
    elapsed = now_r - cur.wstart;
    restart = !cur.seen || (now_r < cur.wstart) || (elapsed > {32'd0, wlen_r});
    whits   = restart ? 32'd1 : ((cur.whits == '1) ? cur.whits : cur.whits + 1'b1);
    thits   = cur.total + 1'b1;
    trip    = whits > limit_r;
    wr_d.key    = key_r;
    wr_d.total  = thits;
    wr_d.wstart = restart ? now_r : cur.wstart;
    wr_d.whits  = whits;
    wr_d.seen   = 1'b1;
  end

  logic [CW-1:0] sites_r;
  logic [63:0]   trips_r, ovf_r, halts_r, conts_r;
  logic          fin, fin_halt;

  assign fin      = cmd.early_halt || cmd.full_halt || cmd.update;
  assign fin_halt = cmd.early_halt || cmd.full_halt || (cmd.update && trip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sites_r <= '0;
      trips_r <= '0;
      ovf_r   <= '0;
      halts_r <= '0;
      conts_r <= '0;
    end else begin
      if (cmd.update && empty) sites_r <= sites_r + 1'b1;
      if (cmd.update && trip) trips_r <= trips_r + 1'b1;
      if (cmd.full_halt) ovf_r <= ovf_r + 1'b1;
      if (fin && fin_halt) halts_r <= halts_r + 1'b1;
      if (fin && !fin_halt) conts_r <= conts_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_halt             <= fin_halt;
      out_first_hit        <= cmd.update && !cur.seen;
      out_window_hit_count <= cmd.update ? whits : '0;
      out_total_hit_count  <= cmd.update ? thits : '0;
      out_summary_due      <= cmd.update && !trip && cur.seen &&
                              (thits[9:0] & psbb_pkg::SUMMARY_MASK) == '0;
      if (cmd.early_halt)
        out_halt_reason <= (!allowed) ? psbb_pkg::RSN_POLICY : psbb_pkg::RSN_ZERO;
      else if (cmd.full_halt) out_halt_reason <= psbb_pkg::RSN_FULL;
      else out_halt_reason <= trip ? psbb_pkg::RSN_BREAK : psbb_pkg::RSN_NONE;
    end
  end

  assign out_distinct_sites     = sites_r;
  assign out_breaker_trip_count = trips_r;
  assign out_overflow_count     = ovf_r;
  assign out_halt_count         = halts_r;
  assign out_continue_count     = conts_r;

  a_sites_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sites_r <= CW'(TABLE_SLOTS))
    else $error("site count over table size");
  a_no_read_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> !cmd.read && !cmd.update)
    else $error("access during clearing pass");
  a_sites_step: assert property (@(posedge clk) disable iff (!rst_n)
    sites_r != $past(sites_r) |-> $past(cmd.update))
    else $error("site count moved without insert");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for per_site_burst_breaker_unit
// Drives request words through the input channel, keeps its own model of the
// site table, window counters and running totals, and compares every result
// word field by field. Covers strict and policy halts, zero keys, windows,
// breaker trips, summaries, probe chains and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned SLOTS      = psbb_pkg::TABLE_SLOTS_DEF;
  localparam int unsigned CW         = $clog2(SLOTS + 1);
  localparam int          IDLE_LIMIT = 30000;
  localparam int          HOLD_CYC   = 400;
  localparam int          RAND_WORDS = 140;

  localparam logic [2:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [2:0] CFG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [1:0]  feature_id;
    logic [2:0]  subsystem_id;
    logic        site_valid;
    logic [63:0] site_key;
    logic [63:0] now_ms;
  } request_t;

  typedef struct packed {
    logic              halt;
    psbb_pkg::reason_t reason;
    logic              first_hit;
    logic [31:0]       win_count;
    logic [63:0]       tot_count;
    logic              summary_due;
    logic [CW-1:0]     distinct_sites;
    logic [63:0]       trips;
    logic [63:0]       overflows;
    logic [63:0]       halts;
    logic [63:0]       continues;
  } decision_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_write;
  logic [2:0]    cfg_index;
  logic [31:0]   cfg_data;
  logic          in_valid;
  logic          in_stall;
  logic [1:0]    in_feature_id;
  logic [2:0]    in_subsystem_id;
  logic          in_site_valid;
  logic [63:0]   in_site_key;
  logic [63:0]   in_now_ms;
  logic          out_valid;
  logic          out_stall;
  logic          out_halt;
  logic [2:0]    out_halt_reason;
  logic          out_first_hit;
  logic [31:0]   out_window_hit_count;
  logic [63:0]   out_total_hit_count;
  logic          out_summary_due;
  logic [CW-1:0] out_distinct_sites;
  logic [63:0]   out_breaker_trip_count;
  logic [63:0]   out_overflow_count;
  logic [63:0]   out_halt_count;
  logic [63:0]   out_continue_count;

  per_site_burst_breaker_unit uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_feature_id(in_feature_id), .in_subsystem_id(in_subsystem_id),
    .in_site_valid(in_site_valid), .in_site_key(in_site_key),
    .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_halt(out_halt), .out_halt_reason(out_halt_reason),
    .out_first_hit(out_first_hit), .out_window_hit_count(out_window_hit_count),
    .out_total_hit_count(out_total_hit_count), .out_summary_due(out_summary_due),
    .out_distinct_sites(out_distinct_sites),
    .out_breaker_trip_count(out_breaker_trip_count),
    .out_overflow_count(out_overflow_count), .out_halt_count(out_halt_count),
    .out_continue_count(out_continue_count)
  );

  // model configuration
  logic        m_unsafe;
  logic [3:0]  m_feat_mask;
  logic [7:0]  m_sub_mask;
  logic [31:0] m_burst;
  logic [31:0] m_window;

  // model table and totals
  logic [63:0]   tbl_key   [SLOTS];
  logic [63:0]   tbl_total [SLOTS];
  logic [63:0]   tbl_wstart[SLOTS];
  logic [31:0]   tbl_whits [SLOTS];
  logic          tbl_seen  [SLOTS];
  logic [CW-1:0] site_cnt;
  logic [63:0]   trip_cnt, ovf_cnt, halt_cnt, cont_cnt;

  decision_t pending_decisions[$];

  int  mismatches, words_sent, words_checked, idle_cycles;
  int  burst_left, stall_mode, stall_phase;
  int  sum_seen, trip_seen;
  bit  hold_req, holding;
  logic [63:0] cur_now;
  logic [63:0] key_pool[64];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic decide_request(input request_t r);
    decision_t d;
    int        idx, s, p;
    bit        restart;
    d = '0;
    d.reason = psbb_pkg::RSN_NONE;
    idx = -1;
    if (!(m_unsafe && m_feat_mask[r.feature_id] && m_sub_mask[r.subsystem_id] &&
          r.site_valid)) begin
      d.halt = 1'b1;
      d.reason = psbb_pkg::RSN_POLICY;
    end else if (r.site_key == 64'd0) begin
      d.halt = 1'b1;
      d.reason = psbb_pkg::RSN_ZERO;
    end else begin
      s = int'(r.site_key % SLOTS);
      for (p = 0; p < SLOTS && idx < 0; p++) begin
        if (tbl_key[(s + p) % SLOTS] == r.site_key) begin
          idx = (s + p) % SLOTS;
        end else if (tbl_key[(s + p) % SLOTS] == 64'd0) begin
          idx = (s + p) % SLOTS;
          tbl_key[idx] = r.site_key;
          tbl_total[idx] = '0;
          tbl_wstart[idx] = '0;
          tbl_whits[idx] = '0;
          tbl_seen[idx] = 1'b0;
          site_cnt++;
        end
      end
      if (idx < 0) begin
        ovf_cnt++;
        d.halt = 1'b1;
        d.reason = psbb_pkg::RSN_FULL;
      end else begin
        restart = !tbl_seen[idx] || r.now_ms < tbl_wstart[idx] ||
                  (r.now_ms - tbl_wstart[idx]) > {32'd0, m_window};
        if (restart) begin
          tbl_wstart[idx] = r.now_ms;
          tbl_whits[idx] = '0;
        end
        if (tbl_whits[idx] != 32'hFFFF_FFFF) tbl_whits[idx]++;
        tbl_total[idx]++;
        d.first_hit = !tbl_seen[idx];
        tbl_seen[idx] = 1'b1;
        d.win_count = tbl_whits[idx];
        d.tot_count = tbl_total[idx];
        if (d.win_count > m_burst) begin
          trip_cnt++;
          d.halt = 1'b1;
          d.reason = psbb_pkg::RSN_BREAK;
        end else if (!d.first_hit && d.tot_count[9:0] == 10'd0) begin
          d.summary_due = 1'b1;
        end
      end
    end
    if (d.halt) halt_cnt++;
    else cont_cnt++;
    d.distinct_sites = site_cnt;
    d.trips = trip_cnt;
    d.overflows = ovf_cnt;
    d.halts = halt_cnt;
    d.continues = cont_cnt;
    pending_decisions.push_back(d);
  endtask

  // sender: bursts of random length with random gaps
  task automatic send_word(input request_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_feature_id = r.feature_id;
    in_subsystem_id = r.subsystem_id;
    in_site_valid = r.site_valid;
    in_site_key = r.site_key;
    in_now_ms = r.now_ms;
    do @(posedge clk); while (in_stall);
    decide_request(r);
    words_sent++;
    burst_left--;
  endtask

  task automatic hit(input logic [63:0] key, input logic [63:0] now_ms);
    request_t r;
    r.feature_id = 2'($urandom_range(0, 3));
    r.subsystem_id = 3'($urandom_range(0, 7));
    r.site_valid = 1'b1;
    r.site_key = key;
    r.now_ms = now_ms;
    send_word(r);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      psbb_pkg::CFG_MODE_UNSAFE:  m_unsafe = val[0];
      psbb_pkg::CFG_FEATURE_MASK: m_feat_mask = val[3:0];
      psbb_pkg::CFG_SUBSYS_MASK:  m_sub_mask = val[7:0];
      psbb_pkg::CFG_BURST_LIMIT:  m_burst = val;
      psbb_pkg::CFG_WINDOW_LEN:   m_window = val;
      default: ;
    endcase
  endtask

  task automatic open_all(input logic [31:0] limit, input logic [31:0] win);
    write_reg(psbb_pkg::CFG_MODE_UNSAFE, 32'd1);
    write_reg(psbb_pkg::CFG_FEATURE_MASK, 32'hF);
    write_reg(psbb_pkg::CFG_SUBSYS_MASK, 32'hFF);
    write_reg(psbb_pkg::CFG_BURST_LIMIT, limit);
    write_reg(psbb_pkg::CFG_WINDOW_LEN, win);
  endtask

  task automatic test_strict_reset;
    request_t r;
    int i;
    for (i = 0; i < 4; i++) begin
      r.feature_id = 2'(i);
      r.subsystem_id = 3'(7 - 2 * i);
      r.site_valid = i[0];
      r.site_key = (i == 0) ? 64'd0 : {64{1'b1}};
      r.now_ms = (i == 1) ? {64{1'b1}} : 64'd5;
      send_word(r);
    end
    drain();
  endtask

  task automatic test_policy_gates;
    request_t r;
    write_reg(psbb_pkg::CFG_MODE_UNSAFE, 32'hFFFF_FFFE);
    write_reg(psbb_pkg::CFG_FEATURE_MASK, 32'h0000_0005);
    write_reg(psbb_pkg::CFG_SUBSYS_MASK, 32'hFFFF_FF81);
    write_reg(CFG_UNUSED_LO, 32'd0);
    write_reg(CFG_UNUSED_HI, 32'hFFFF_FFFF);
    r = '{2'd0, 3'd0, 1'b1, 64'h1234, 64'd0};
    send_word(r);
    drain();
    write_reg(psbb_pkg::CFG_MODE_UNSAFE, 32'd1);
    r = '{2'd0, 3'd0, 1'b1, 64'h1234, 64'd0};  send_word(r);
    r = '{2'd1, 3'd0, 1'b1, 64'h1234, 64'd1};  send_word(r);
    r = '{2'd2, 3'd7, 1'b1, 64'h1234, 64'd2};  send_word(r);
    r = '{2'd2, 3'd3, 1'b1, 64'h1234, 64'd3};  send_word(r);
    r = '{2'd0, 3'd7, 1'b0, 64'h1234, 64'd4};  send_word(r);
    r = '{2'd0, 3'd7, 1'b1, 64'd0, 64'd5};     send_word(r);
    drain();
  endtask

  task automatic test_window_breaker;
    logic [63:0] k;
    k = 64'hFFFF_FFFF_FFFF_F000;
    open_all(32'd3, 32'd10);
    hit(k, 64'd0);
    hit(k, 64'd0);
    hit(k, 64'd10);
    hit(k, 64'd10);
    hit(k, 64'd11);
    hit(k, 64'd5);
    hit(k, {64{1'b1}});
    hit(64'd1, {64{1'b1}});
    hit(64'd4097, 64'd0);
    drain();
    write_reg(psbb_pkg::CFG_BURST_LIMIT, 32'd0);
    write_reg(psbb_pkg::CFG_WINDOW_LEN, 32'd0);
    hit(64'd4097, 64'd0);
    hit(64'd4097, 64'd0);
    hit(64'd4097, 64'd1);
    drain();
    open_all(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    hit(64'd8193, 64'd0);
    hit(64'd8193, 64'hFFFF_FFFF);
    hit(64'd8193, 64'h1_0000_0000);
    drain();
  endtask

  task automatic test_summary;
    int i;
    for (i = 0; i < 1030; i++) hit(64'hA5A5_0000_0000_0777, cur_now);
    drain();
  endtask

  task automatic random_config;
    int c;
    c = $urandom_range(0, 9);
    write_reg(psbb_pkg::CFG_MODE_UNSAFE,
              (c == 0) ? 32'($urandom) & ~32'd1 : $urandom | 32'd1);
    write_reg(psbb_pkg::CFG_FEATURE_MASK, (c < 6) ? 32'hFFFF_FFFF : $urandom);
    write_reg(psbb_pkg::CFG_SUBSYS_MASK, (c < 6) ? 32'hFFFF_FFFF : $urandom);
    case ($urandom_range(0, 4))
      0: write_reg(psbb_pkg::CFG_BURST_LIMIT, 32'd1);
      1: write_reg(psbb_pkg::CFG_BURST_LIMIT, 32'hFFFF_FFFF);
      default: write_reg(psbb_pkg::CFG_BURST_LIMIT, $urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(psbb_pkg::CFG_WINDOW_LEN, 32'd1);
      1: write_reg(psbb_pkg::CFG_WINDOW_LEN, 32'hFFFF_FFFF);
      default: write_reg(psbb_pkg::CFG_WINDOW_LEN, $urandom_range(5, 200));
    endcase
  endtask

  task automatic random_request(output request_t r);
    int c;
    c = $urandom_range(0, 99);
    r.feature_id = 2'($urandom);
    r.subsystem_id = 3'($urandom);
    r.site_valid = ($urandom_range(0, 19) != 0);
    if (c < 85) r.site_key = key_pool[$urandom_range(0, 63)];
    else if (c < 95) r.site_key = {$urandom, $urandom};
    else r.site_key = 64'd0;
    c = $urandom_range(0, 99);
    if (c < 75) cur_now += $urandom_range(0, 25);
    else if (c < 85) cur_now += $urandom_range(100, 100000);
    else if (c < 95) cur_now -= $urandom_range(1, 50);
    else cur_now = {$urandom, $urandom};
    r.now_ms = cur_now;
  endtask

  task automatic test_random_traffic;
    request_t r;
    int i, j;
    for (i = 0; i < 64; i++) begin
      key_pool[i] = {$urandom, $urandom};
      if (i < 40) key_pool[i][11:0] = 12'(4000 + (i % 6));
      if (key_pool[i] == 64'd0) key_pool[i] = 64'd4000;
    end
    for (i = 0; i < 6; i++) begin
      random_config();
      for (j = 0; j < RAND_WORDS; j++) begin
        random_request(r);
        send_word(r);
      end
      drain();
    end
  endtask

  task automatic test_backpressure;
    request_t r;
    int i;
    open_all(32'd5, 32'd50);
    hold_req = 1'b1;
    for (i = 0; i < 60; i++) begin
      random_request(r);
      send_word(r);
      if (i == 5) hold_req = 1'b0;
    end
    drain();
  endtask

  // receiver stall pattern, with an optional long hold-off
  initial begin
    int hold_left;
    out_stall = 1'b0;
    stall_mode = 0;
    stall_phase = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      stall_phase++;
      if (stall_phase % 150 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_req && !holding) begin
        holding = 1'b1;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 9) < 3);
          2: out_stall = (stall_phase % 5 < 2);
          default: out_stall = ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    decision_t got, exp;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_halt, psbb_pkg::reason_t'(out_halt_reason), out_first_hit,
              out_window_hit_count, out_total_hit_count, out_summary_due,
              out_distinct_sites, out_breaker_trip_count, out_overflow_count,
              out_halt_count, out_continue_count};
      words_checked++;
      if (got.summary_due) sum_seen++;
      if (got.reason == psbb_pkg::RSN_BREAK) trip_seen++;
      if (pending_decisions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result word %p", got);
      end else begin
        exp = pending_decisions.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: word %0d\n  exp %p\n  got %p", words_checked, exp, got);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_feature_id = '0;
    in_subsystem_id = '0;
    in_site_valid = 1'b0;
    in_site_key = '0;
    in_now_ms = '0;
    hold_req = 1'b0;
    holding = 1'b0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    idle_cycles = 0;
    burst_left = 0;
    sum_seen = 0;
    trip_seen = 0;
    cur_now = 64'd100;
    m_unsafe = 1'b0;
    m_feat_mask = '0;
    m_sub_mask = '0;
    m_burst = psbb_pkg::BURST_LIMIT_RST;
    m_window = psbb_pkg::WINDOW_LEN_RST;
    for (i = 0; i < SLOTS; i++) begin
      tbl_key[i] = '0;
      tbl_total[i] = '0;
      tbl_wstart[i] = '0;
      tbl_whits[i] = '0;
      tbl_seen[i] = 1'b0;
    end
    site_cnt = '0;
    trip_cnt = '0;
    ovf_cnt = '0;
    halt_cnt = '0;
    cont_cnt = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_strict_reset();
    test_policy_gates();
    test_window_breaker();
    test_summary();
    test_random_traffic();
    test_backpressure();

    drain();
    repeat (20) @(posedge clk);
    $display("Run: %0d words sent, %0d results checked, %0d mismatches",
             words_sent, words_checked, mismatches);
    $display("Seen: %0d summaries, %0d breaker trips, %0d sites in table",
             sum_seen, trip_seen, site_cnt);
    if (mismatches == 0 && pending_decisions.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
